### src/mcbq_pkg.sv
// ----------------------------------------------------------------------------
// mcbq_pkg
// shared types, codes and defaults of the broadcast queue with reader counts
// ----------------------------------------------------------------------------
package mcbq_pkg;

   // default sizes handed to the top level parameters
   localparam int DEPTH_DEFAULT           = 16;
   localparam int DATA_WIDTH_DEFAULT      = 32;
   localparam int MAX_SUBSCRIBERS_DEFAULT = 255;

   // operation codes on the request channel
   typedef enum logic [2:0] {
      CMD_SUBSCRIBE   = 3'd0,
      CMD_UNSUBSCRIBE = 3'd1,
      CMD_PUSH        = 3'd2,
      CMD_POP         = 3'd3,
      CMD_HAS         = 3'd4
   } cmd_code_type;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_ENTRY  = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_DROPPED   = 3'd3,
      STATUS_SUB_LIMIT = 3'd4
   } status_code_type;

   // request transfer payload
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] entry_index;
      logic [31:0] push_word;
   } req_payload_type;

   // response transfer payload
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] next_index;
      logic [31:0] pop_word;
      logic        present;
      logic [4:0]  occupancy;
      logic        notify;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic pop_write;
      logic walk_read;
      logic walk_write;
      logic retire_read;
      logic retire_step;
      logic load_out;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [2:0] cmd;
      logic       pop_hit;
      logic       unsub_walk;
      logic       walk_last;
      logic       fill_zero;
      logic       head_free;
   } dp_status_type;

endpackage

### src/multi_consumer_broadcast_queue_unit.sv
// ----------------------------------------------------------------------------
// multi_consumer_broadcast_queue_unit
// broadcast queue whose words each carry a count of readers still to take them
// ----------------------------------------------------------------------------
// One request is handled at a time; the finished response sits in an output
// register so the next request is taken while it waits. Subscribe, push, has,
// unknown codes and a pop or unsubscribe that touches nothing go from the
// capture state through execute straight to the done state. A pop of a held
// entry writes back its decremented reader count, then runs the head
// retirement scan; an unsubscribe decrements the count of each entry from its
// start index to the tail, then runs the retirement scan. The scan ends at
// once when the queue is empty, else reads each head entry in turn and
// retires it while its count is zero. A stalled response still in the output
// register holds the finished result until it transfers. Each entry update is
// a read and then a write, through the single read and single write port of
// the count memory, whose read data is registered.
// No clearing pass after reset is needed.
// ----------------------------------------------------------------------------
module multi_consumer_broadcast_queue_unit #(
   parameter int DEPTH           = mcbq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH      = mcbq_pkg::DATA_WIDTH_DEFAULT,
   parameter int MAX_SUBSCRIBERS = mcbq_pkg::MAX_SUBSCRIBERS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mcbq_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mcbq_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);

   mcbq_pkg::ctl_cmd_type   ctl_cmd;
   mcbq_pkg::dp_status_type dp_status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   mcbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   mcbq_dp #(
      .DEPTH           (DEPTH),
      .DATA_WIDTH      (DATA_WIDTH),
      .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload),
      .ctl_cmd     (ctl_cmd),
      .dp_status   (dp_status)
   );

   // one request in flight: a transfer is followed by stall
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in flight");

   // a waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load_out |-> !(rsp_valid && rsp_stall))
      else $error("output register loaded while response stalled");

   // notify only comes with a stored push
   a_notify_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.notify) |-> (rsp_payload.status == mcbq_pkg::STATUS_OK))
      else $error("notify raised on a failed operation");

   // only a drained head entry of a non-empty queue is retired
   a_retire_drained: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.retire_step |-> (dp_status.head_free && !dp_status.fill_zero))
      else $error("retired an entry that still has readers");

endmodule

### src/mcbq_ctrl.sv
// ----------------------------------------------------------------------------
// mcbq_ctrl
// operation sequencer: accepts one request, steps the datapath, hands the result
// ----------------------------------------------------------------------------
module mcbq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mcbq_pkg::dp_status_type dp_status,
   output mcbq_pkg::ctl_cmd_type   ctl_cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_EXEC    = 9'b000000010,
      ST_POP_WR  = 9'b000000100,
      ST_UNS_RD  = 9'b000001000,
      ST_UNS_WR  = 9'b000010000,
      ST_RET_RD  = 9'b000100000,
      ST_RET_CHK = 9'b001000000,
      ST_DONE    = 9'b010000000,
      ST_SPARE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl_cmd.capture = 1'b1;
               state_in        = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl_cmd.exec = 1'b1;
            if (dp_status.cmd == mcbq_pkg::CMD_POP) begin
               state_in = dp_status.pop_hit ? ST_POP_WR : ST_DONE;
            end else if (dp_status.cmd == mcbq_pkg::CMD_UNSUBSCRIBE) begin
               state_in = dp_status.unsub_walk ? ST_UNS_WR : ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP_WR: begin
            ctl_cmd.pop_write = 1'b1;
            state_in          = ST_RET_RD;
         end
         ST_UNS_RD: begin
            ctl_cmd.walk_read = 1'b1;
            state_in          = ST_UNS_WR;
         end
         ST_UNS_WR: begin
            ctl_cmd.walk_write = 1'b1;
            state_in           = dp_status.walk_last ? ST_RET_RD : ST_UNS_RD;
         end
         ST_RET_RD: begin
            if (dp_status.fill_zero) begin
               state_in = ST_DONE;
            end else begin
               ctl_cmd.retire_read = 1'b1;
               state_in            = ST_RET_CHK;
            end
         end
         ST_RET_CHK: begin
            if (dp_status.head_free) begin
               ctl_cmd.retire_step = 1'b1;
               state_in            = ST_RET_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl_cmd.load_out = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid holds until its transfer
   always_comb begin
      if (ctl_cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/mcbq_dp.sv
// ----------------------------------------------------------------------------
// mcbq_dp
// queue datapath: word and count memories, head pointers, walk counter, result
// ----------------------------------------------------------------------------
module mcbq_dp #(
   parameter int DEPTH           = mcbq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH      = mcbq_pkg::DATA_WIDTH_DEFAULT,
   parameter int MAX_SUBSCRIBERS = mcbq_pkg::MAX_SUBSCRIBERS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mcbq_pkg::req_payload_type req_payload,
   input  logic                     csr_write,
   input  logic                     csr_data,
   output mcbq_pkg::rsp_payload_type rsp_payload,
   input  mcbq_pkg::ctl_cmd_type     ctl_cmd,
   output mcbq_pkg::dp_status_type   dp_status
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int SUB_W  = $clog2(MAX_SUBSCRIBERS + 1);
   localparam int SUM_W  = FILL_W + 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);
   localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(DEPTH);
   localparam logic [SUB_W-1:0]  SUB_LIMIT = SUB_W'(MAX_SUBSCRIBERS);

   // slot of an offset from the head, offset at most DEPTH
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                input logic [FILL_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   // storage
   logic [DATA_WIDTH-1:0] word_mem [DEPTH];
   logic [SUB_W-1:0]      count_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_word_ff;
   logic [SUB_W-1:0]      rd_count_ff;

   // queue control state
   logic [31:0]       head_abs_ff, head_abs_in;
   logic [SLOT_W-1:0] head_slot_ff, head_slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUB_W-1:0]  subs_ff, subs_in;
   logic              notify_en_ff, notify_en_in;

   // captured request and walk state
   logic [2:0]            cmd_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [FILL_W-1:0]     off_ff;
   logic                  hit_ff;
   logic                  walk_ok_ff;
   logic [SLOT_W-1:0]     walk_slot_ff;
   logic [FILL_W-1:0]     walk_left_ff;

   // result under construction and output register
   logic [2:0]                res_status_ff;
   logic [31:0]               res_next_ff;
   logic [31:0]               res_pop_ff;
   logic                      res_present_ff;
   logic                      res_notify_ff;
   mcbq_pkg::rsp_payload_type out_ff;

   // combinational helpers
   logic [31:0]       offset;
   logic [31:0]       fill_ext;
   logic [63:0]       push_ext;
   logic [63:0]       pop_ext;
   logic              req_hit;
   logic [SLOT_W-1:0] start_slot;
   logic [SLOT_W-1:0] tail_slot;
   logic [SLOT_W-1:0] rd_addr;
   logic [SUB_W-1:0]  count_dec;
   logic              push_ok;
   logic              word_we;
   logic              count_we;
   logic [SLOT_W-1:0] wr_addr;
   logic [SUB_W-1:0]  wr_count;

   // index distance from the head of the incoming request
   assign offset   = req_payload.entry_index - head_abs_ff;
   assign fill_ext = 32'(fill_ff);
   assign req_hit  = (offset < fill_ext);
   assign push_ext = 64'(req_payload.push_word);
   assign pop_ext  = 64'(rd_word_ff);

   assign start_slot = slot_of(head_slot_ff, off_ff);
   assign tail_slot  = slot_of(head_slot_ff, fill_ff);
   assign count_dec  = (rd_count_ff == '0) ? '0 : rd_count_ff - 1'b1;
   assign push_ok    = (subs_ff != '0) && (fill_ff != FULL_FILL);

   // memory port selection
   always_comb begin
      if (ctl_cmd.walk_read) begin
         rd_addr = walk_slot_ff;
      end else if (ctl_cmd.retire_read) begin
         rd_addr = head_slot_ff;
      end else begin
         rd_addr = start_slot;
      end
      word_we  = ctl_cmd.exec && (cmd_ff == mcbq_pkg::CMD_PUSH) && push_ok;
      count_we = word_we || ctl_cmd.pop_write || ctl_cmd.walk_write;
      wr_addr  = word_we ? tail_slot : walk_slot_ff;
      wr_count = word_we ? subs_ff : count_dec;
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[wr_addr] <= word_ff;
      end
      if (count_we) begin
         count_mem[wr_addr] <= wr_count;
      end
      rd_word_ff  <= word_mem[rd_addr];
      rd_count_ff <= count_mem[rd_addr];
   end

   // queue control state updates
   always_comb begin
      head_abs_in  = head_abs_ff;
      head_slot_in = head_slot_ff;
      fill_in      = fill_ff;
      subs_in      = subs_ff;
      notify_en_in = notify_en_ff;
      if (csr_write) begin
         notify_en_in = csr_data;
      end
      if (ctl_cmd.exec) begin
         if (cmd_ff == mcbq_pkg::CMD_SUBSCRIBE) begin
            if (subs_ff < SUB_LIMIT) begin
               subs_in = subs_ff + 1'b1;
            end
         end else if (cmd_ff == mcbq_pkg::CMD_UNSUBSCRIBE) begin
            if (subs_ff != '0) begin
               subs_in = subs_ff - 1'b1;
            end
         end else if (cmd_ff == mcbq_pkg::CMD_PUSH) begin
            if (push_ok) begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end
      // retire a drained head entry
      if (ctl_cmd.retire_step) begin
         head_abs_in  = head_abs_ff + 32'd1;
         head_slot_in = slot_inc(head_slot_ff);
         fill_in      = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_abs_ff  <= '0;
         head_slot_ff <= '0;
         fill_ff      <= '0;
         subs_ff      <= '0;
         notify_en_ff <= 1'b0;
      end else begin
         head_abs_ff  <= head_abs_in;
         head_slot_ff <= head_slot_in;
         fill_ff      <= fill_in;
         subs_ff      <= subs_in;
         notify_en_ff <= notify_en_in;
      end
   end

   // request capture, walk pointer and result fields
   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         cmd_ff         <= req_payload.cmd;
         word_ff        <= push_ext[DATA_WIDTH-1:0];
         off_ff         <= offset[31] ? '0 : offset[FILL_W-1:0];
         hit_ff         <= req_hit;
         walk_ok_ff     <= offset[31] ? (fill_ff != '0) : req_hit;
         res_status_ff  <= mcbq_pkg::STATUS_OK;
         res_next_ff    <= '0;
         res_pop_ff     <= '0;
         res_present_ff <= 1'b0;
         res_notify_ff  <= 1'b0;
      end
      if (ctl_cmd.exec) begin
         walk_slot_ff <= start_slot;
         walk_left_ff <= fill_ff - off_ff;
         if (cmd_ff == mcbq_pkg::CMD_SUBSCRIBE) begin
            res_next_ff <= head_abs_ff + fill_ext;
            if (subs_ff >= SUB_LIMIT) begin
               res_status_ff <= mcbq_pkg::STATUS_SUB_LIMIT;
            end
         end else if (cmd_ff == mcbq_pkg::CMD_PUSH) begin
            if (subs_ff == '0) begin
               res_status_ff <= mcbq_pkg::STATUS_DROPPED;
            end else if (fill_ff == FULL_FILL) begin
               res_status_ff <= mcbq_pkg::STATUS_FULL;
            end else begin
               res_notify_ff <= notify_en_ff;
            end
         end else if (cmd_ff == mcbq_pkg::CMD_POP) begin
            if (!hit_ff) begin
               res_status_ff <= mcbq_pkg::STATUS_NO_ENTRY;
            end
         end else if (cmd_ff == mcbq_pkg::CMD_HAS) begin
            res_present_ff <= hit_ff;
         end
      end
      if (ctl_cmd.pop_write) begin
         res_pop_ff <= pop_ext[31:0];
      end
      // step the unsubscribe walk
      if (ctl_cmd.walk_write) begin
         walk_slot_ff <= slot_inc(walk_slot_ff);
         walk_left_ff <= walk_left_ff - 1'b1;
      end
      if (ctl_cmd.load_out) begin
         out_ff.status     <= res_status_ff;
         out_ff.next_index <= res_next_ff;
         out_ff.pop_word   <= res_pop_ff;
         out_ff.present    <= res_present_ff;
         out_ff.occupancy  <= fill_ext[4:0];
         out_ff.notify     <= res_notify_ff;
      end
   end

   // status to the controller
   always_comb begin
      dp_status.cmd        = cmd_ff;
      dp_status.pop_hit    = hit_ff;
      dp_status.unsub_walk = (subs_ff != '0) && walk_ok_ff;
      dp_status.walk_last  = (walk_left_ff == FILL_W'(1));
      dp_status.fill_zero  = (fill_ff == '0);
      dp_status.head_free  = (rd_count_ff == '0);
   end

   assign rsp_payload = out_ff;

endmodule
